// ----- sv/cswq_pkg.sv -----
package cswq_pkg;

	localparam int ID_W       = 8;
	localparam int AMT_W      = 8;
	localparam int COUNT_W    = 16;
	localparam int CFG_W      = 15;
	localparam int OUTCOME_W  = 3;
	localparam int REL_W      = 7;
	localparam int RESULT_CAP = 64;
	localparam int COUNT_MAX  = 32767;

	localparam logic signed [COUNT_W-1:0] COUNT_ONE = 1;

	localparam logic REQ_WAIT   = 1'b0;
	localparam logic REQ_SIGNAL = 1'b1;

	localparam logic REG_INITIAL_COUNT = 1'b0;

	localparam logic [OUTCOME_W-1:0] OUT_GRANTED  = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_BLOCKED  = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_RELEASED = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_NONE     = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_NEGATIVE = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd5;

	typedef struct packed {
		logic                    req_type;
		logic [ID_W-1:0]         thread_id;
		logic signed [AMT_W-1:0] signal_amount;
	} cswq_req_t;

	typedef struct packed {
		logic [OUTCOME_W-1:0]      outcome;
		logic [ID_W-1:0]           waiter_id;
		logic signed [AMT_W-1:0]   signal_return;
		logic signed [COUNT_W-1:0] count_value;
		logic                      last;
	} cswq_rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_RELEASE
	} cswq_state_t;

endpackage

// ----- sv/cswq_ram.sv -----
module cswq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/counting_semaphore_wait_queue.sv -----
// Counting semaphore with a FIFO queue of blocked thread ids. A request is taken when start is
// high and busy is low; each result word appears on rsp for one cycle with valid high and must be
// taken then since the receiver cannot stall. A wait, a negative signal or a signal that finds the
// queue empty gives one word, on the cycle after acceptance. A signal that releases r queued
// threads gives r words, one per cycle, the first once the block is in its release state and
// the word has been registered, each paced by one registered read of the waiter memory.
// At most 64 threads are released per signal. Writing initial_count reloads the count and empties
// the queue; write it only while the block is idle.
module counting_semaphore_wait_queue #(
	parameter int MAX_WAITERS    = 64,
	parameter int THREAD_ID_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	input  cswq_pkg::cswq_req_t req,
	output logic                busy,
	output logic                valid,
	output cswq_pkg::cswq_rsp_t rsp
);

	import cswq_pkg::*;

	localparam int FillW = $clog2(MAX_WAITERS + 1);
	localparam int PtrW  = $clog2(MAX_WAITERS);
	localparam int IdW   = (THREAD_ID_BITS < ID_W) ? THREAD_ID_BITS : ID_W;

	cswq_state_t               state_q, state_d;
	logic [CFG_W-1:0]          initial_q;
	logic signed [COUNT_W-1:0] count_q, count_d;
	logic [FillW-1:0]          fill_q, fill_d;
	logic [PtrW-1:0]           head_q, head_d, tail_q, tail_d;
	logic [PtrW-1:0]           head_inc, tail_inc;
	logic [REL_W-1:0]          rem_q, rem_d, rel_q, rel_d, extra_q, extra_d;
	logic                      valid_q, valid_d;
	cswq_rsp_t                 rsp_q, rsp_d;

	logic                      cfg_wr;
	logic [IdW-1:0]            id_m;
	logic [REL_W-1:0]          n_u, fill_cap, rel_new;
	logic signed [COUNT_W:0]   sum_wide;
	logic signed [COUNT_W-1:0] sum_sat;
	logic                      fill_full;
	logic                      ram_we;
	logic [PtrW-1:0]           ram_raddr;
	logic [IdW-1:0]            ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_INITIAL_COUNT);
	assign prdata = (paddr[2] == REG_INITIAL_COUNT) ? 32'(initial_q) : '0;

	assign busy  = (state_q != ST_IDLE);
	assign valid = valid_q;
	assign rsp   = rsp_q;

	assign id_m      = req.thread_id[IdW-1:0];
	assign head_inc  = (head_q == PtrW'(MAX_WAITERS - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc  = (tail_q == PtrW'(MAX_WAITERS - 1)) ? '0 : tail_q + 1'b1;
	assign fill_full = (int'(fill_q) >= MAX_WAITERS);

	assign n_u      = (req.signal_amount == '0) ? REL_W'(1) : req.signal_amount[REL_W-1:0];
	assign fill_cap = (int'(fill_q) > RESULT_CAP) ? REL_W'(RESULT_CAP) : REL_W'(fill_q);
	assign rel_new  = (n_u < fill_cap) ? n_u : fill_cap;

	assign sum_wide = $signed({count_q[COUNT_W-1], count_q}) + $signed((COUNT_W + 1)'(n_u));
	assign sum_sat  = (sum_wide > $signed((COUNT_W + 1)'(COUNT_MAX))) ?
		COUNT_W'(COUNT_MAX) : sum_wide[COUNT_W-1:0];

	cswq_ram #(
		.WIDTH (IdW),
		.DEPTH (MAX_WAITERS)
	) u_waiters (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (id_m),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		fill_d    = fill_q;
		head_d    = head_q;
		tail_d    = tail_q;
		rem_d     = rem_q;
		rel_d     = rel_q;
		extra_d   = extra_q;
		valid_d   = 1'b0;
		rsp_d     = rsp_q;
		ram_we    = 1'b0;
		ram_raddr = head_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_wr) begin
					count_d = COUNT_W'(pwdata[CFG_W-1:0]);
					fill_d  = '0;
					head_d  = '0;
					tail_d  = '0;
				end else if (start) begin
					valid_d            = 1'b1;
					rsp_d.last         = 1'b1;
					rsp_d.waiter_id    = '0;
					rsp_d.signal_return = '0;
					if (req.req_type == REQ_WAIT) begin
						rsp_d.waiter_id = ID_W'(id_m);
						if (count_q > 0) begin
							rsp_d.outcome = OUT_GRANTED;
							count_d       = count_q - COUNT_ONE;
						end else if (fill_full) begin
							rsp_d.outcome = OUT_FULL;
						end else begin
							rsp_d.outcome = OUT_BLOCKED;
							ram_we        = 1'b1;
							tail_d        = tail_inc;
							fill_d        = fill_q + 1'b1;
							count_d       = count_q - COUNT_ONE;
						end
					end else if (req.signal_amount < 0) begin
						rsp_d.outcome       = OUT_NEGATIVE;
						rsp_d.signal_return = req.signal_amount;
					end else if (rel_new == '0) begin
						rsp_d.outcome = OUT_NONE;
						count_d       = sum_sat;
					end else begin
						valid_d = 1'b0;
						state_d = ST_RELEASE;
						rem_d   = rel_new;
						rel_d   = rel_new;
						extra_d = n_u - rel_new;
					end
					rsp_d.count_value = count_d;
				end
			end
			ST_RELEASE: begin
				valid_d             = 1'b1;
				rsp_d.outcome       = OUT_RELEASED;
				rsp_d.waiter_id     = ID_W'(ram_rdata);
				rsp_d.signal_return = AMT_W'(rel_q);
				rsp_d.last          = (rem_q == REL_W'(1));
				head_d              = head_inc;
				ram_raddr           = head_inc;
				fill_d              = fill_q - 1'b1;
				rem_d               = rem_q - 1'b1;
				count_d             = count_q + COUNT_ONE;
				if (rsp_d.last && fill_q == FillW'(1)) begin
					count_d = count_q + COUNT_ONE + COUNT_W'(extra_q);
				end
				if (rsp_d.last) begin
					state_d = ST_IDLE;
				end
				rsp_d.count_value = count_d;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			initial_q <= '0;
			count_q   <= '0;
			fill_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			rem_q     <= '0;
			valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			fill_q  <= fill_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			rem_q   <= rem_d;
			valid_q <= valid_d;
			if (cfg_wr) begin
				initial_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		rel_q   <= rel_d;
		extra_q <= extra_d;
		rsp_q   <= rsp_d;
	end

	a_release_has_waiter: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELEASE |-> fill_q != '0)
		else $error("release with empty queue");

	a_count_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != '0 |-> (count_q + COUNT_W'(fill_q)) == '0)
		else $error("count out of step with queue fill");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_WAITERS)
		else $error("queue fill beyond capacity");

	a_release_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && rsp_q.outcome == OUT_RELEASED && !rsp_q.last |=> valid_q)
		else $error("gap inside a release burst");

endmodule

// ----- bench/cswq_checker.sv -----
module cswq_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	input  logic                start,
	input  logic                busy,
	input  cswq_pkg::cswq_req_t req,
	input  logic                valid,
	input  cswq_pkg::cswq_rsp_t rsp,
	output int                  pending,
	output int                  errors
);
	timeunit 1ns;
	timeprecision 1ps;

	import cswq_pkg::*;

	localparam int DEPTH = 64;

	logic [CFG_W-1:0] initial_count = '0;
	int               sem = 0;
	logic [ID_W-1:0]  waiters [DEPTH];
	int               head = 0;
	int               tail = 0;
	int               fill = 0;
	cswq_rsp_t        words_due [$];
	int               fails = 0;

	function automatic int saturate(int c);
		return (c > COUNT_MAX) ? COUNT_MAX : c;
	endfunction

	function automatic void reload();
		sem  = int'(initial_count);
		head = 0;
		tail = 0;
		fill = 0;
	endfunction

	function automatic void due(logic [OUTCOME_W-1:0] outcome, logic [ID_W-1:0] id,
			logic signed [AMT_W-1:0] ret, logic last);
		cswq_rsp_t w;
		w.outcome       = outcome;
		w.waiter_id     = id;
		w.signal_return = ret;
		w.count_value   = COUNT_W'(sem);
		w.last          = last;
		words_due.push_back(w);
	endfunction

	function automatic void semaphore_step(cswq_req_t r);
		int              n;
		int              rel;
		logic [ID_W-1:0] who;
		if (r.req_type == REQ_WAIT) begin
			if (sem > 0) begin
				sem--;
				due(OUT_GRANTED, r.thread_id, '0, 1'b1);
			end else if (fill >= DEPTH) begin
				due(OUT_FULL, r.thread_id, '0, 1'b1);
			end else begin
				waiters[tail] = r.thread_id;
				tail = (tail + 1) % DEPTH;
				fill++;
				sem--;
				due(OUT_BLOCKED, r.thread_id, '0, 1'b1);
			end
			return;
		end
		n = int'(r.signal_amount);
		if (n < 0) begin
			due(OUT_NEGATIVE, '0, r.signal_amount, 1'b1);
			return;
		end
		if (n == 0)
			n = 1;
		rel = (fill < n) ? fill : n;
		if (rel > RESULT_CAP)
			rel = RESULT_CAP;
		if (rel == 0) begin
			sem = saturate(sem + n);
			due(OUT_NONE, '0, '0, 1'b1);
			return;
		end
		for (int k = 0; k < rel; k++) begin
			who = waiters[head];
			head = (head + 1) % DEPTH;
			fill--;
			sem++;
			if (k == rel - 1 && fill == 0)
				sem = saturate(sem + (n - rel));
			due(OUT_RELEASED, who, AMT_W'(rel), k == rel - 1);
		end
	endfunction

	always @(posedge clk) begin
		cswq_rsp_t want;
		if (!arst_n) begin
			initial_count = '0;
			reload();
			words_due.delete();
		end else begin
			if (valid) begin
				if (words_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t unexpected word: %0d %0d %0d %0d %0d",
							$realtime, rsp.outcome, rsp.waiter_id, rsp.signal_return,
							rsp.count_value, rsp.last);
				end else begin
					want = words_due.pop_front();
					if (rsp.outcome !== want.outcome || rsp.waiter_id !== want.waiter_id ||
							rsp.signal_return !== want.signal_return ||
							rsp.count_value !== want.count_value || rsp.last !== want.last) begin
						fails++;
						if (fails <= 10)
							$display("%0t mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
								$realtime, want.outcome, want.waiter_id, want.signal_return,
								want.count_value, want.last, rsp.outcome, rsp.waiter_id,
								rsp.signal_return, rsp.count_value, rsp.last);
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_INITIAL_COUNT) begin
				initial_count = pwdata[CFG_W-1:0];
				reload();
			end
			if (start && !busy)
				semaphore_step(req);
		end
		pending <= words_due.size();
		errors  <= fails;
	end

endmodule

// ----- bench/counting_semaphore_wait_queue_test.sv -----
module counting_semaphore_wait_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cswq_pkg::*;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start   = 1'b0;
	cswq_req_t   req     = '0;
	logic        busy;
	logic        valid;
	cswq_rsp_t   rsp;
	int          pending;
	int          errors;
	int          idle_pct = 0;

	counting_semaphore_wait_queue DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.valid   (valid),
		.rsp     (rsp)
	);

	cswq_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.valid   (valid),
		.rsp     (rsp),
		.pending (pending),
		.errors  (errors)
	);

	always #5 clk = ~clk;

	function automatic cswq_req_t mk(logic kind, logic [ID_W-1:0] id,
			logic signed [AMT_W-1:0] amt);
		cswq_req_t r;
		r.req_type      = kind;
		r.thread_id     = id;
		r.signal_amount = amt;
		return r;
	endfunction

	function automatic logic signed [AMT_W-1:0] pick_amount();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return AMT_W'($urandom_range(4));
		else if (roll < 70)
			return AMT_W'($urandom_range(127, 60));
		else if (roll < 85)
			return AMT_W'(-int'($urandom_range(128, 1)));
		else
			return AMT_W'($urandom);
	endfunction

	task automatic issue(cswq_req_t r);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_initial_count(logic [CFG_W-1:0] value);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(REG_INITIAL_COUNT) << 2;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(int count, int wait_pct, int idle);
		idle_pct = idle;
		for (int i = 0; i < count; i++)
			issue(mk(($urandom_range(99) < wait_pct) ? REQ_WAIT : REQ_SIGNAL,
				ID_W'($urandom), pick_amount()));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		issue(mk(REQ_WAIT, 8'h00, 8'sd127));
		issue(mk(REQ_WAIT, 8'hFF, -8'sd128));
		issue(mk(REQ_WAIT, 8'hA5, 8'sd0));
		issue(mk(REQ_SIGNAL, 8'hFF, 8'sd0));
		issue(mk(REQ_SIGNAL, 8'h00, -8'sd128));
		issue(mk(REQ_SIGNAL, 8'h5A, -8'sd1));
		issue(mk(REQ_SIGNAL, 8'h00, 8'sd127));
		issue(mk(REQ_WAIT, 8'h5A, -8'sd1));
		issue(mk(REQ_SIGNAL, 8'hFF, 8'sd1));

		write_initial_count(15'd32767);
		issue(mk(REQ_SIGNAL, 8'h00, 8'sd127));
		issue(mk(REQ_WAIT, 8'h01, 8'sd0));
		issue(mk(REQ_SIGNAL, 8'h00, 8'sd0));
		issue(mk(REQ_SIGNAL, 8'h00, 8'sd2));

		write_initial_count(15'd1);
		issue(mk(REQ_WAIT, 8'h10, 8'sd0));
		issue(mk(REQ_WAIT, 8'h20, 8'sd0));
		issue(mk(REQ_SIGNAL, 8'h00, 8'sd3));
		issue(mk(REQ_WAIT, 8'h30, 8'sd0));

		// queue filled to capacity with extra waits refused, then drained under heavy idling
		write_initial_count(15'd0);
		run_phase(70, 100, 0);
		run_phase(25, 50, 73);
		settle();
		run_phase(25, 50, 73);

		write_initial_count(15'd32767);
		run_phase(40, 30, 7);

		write_initial_count(CFG_W'($urandom_range(32767)));
		run_phase(60, 60, 7);

		write_initial_count(CFG_W'($urandom_range(3)));
		run_phase(60, 65, 0);

		settle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/cswq_pkg.sv
sv/cswq_ram.sv
sv/counting_semaphore_wait_queue.sv
bench/cswq_checker.sv
bench/counting_semaphore_wait_queue_test.sv
